### design/pidw_pkg.sv
`default_nettype none
package pidw_pkg;

  localparam int GAIN_W   = 21;   // signed Q3.18 gain
  localparam int GAIN_FR  = 18;
  localparam int VAL_W    = 32;   // Q16.16 values
  localparam int WIDE_W   = 48;   // Q32.16 integral / derivative
  localparam int PER_W    = 16;   // unsigned Q0.16 period
  localparam int CFG_W    = 63;   // packed kp, ki, kd
  localparam int MUL_A_W  = 22;
  localparam int MUL_B_W  = 49;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int MUL_L_W  = 24;                  // unsigned low slice of operand b
  localparam int MUL_H_W  = MUL_B_W - MUL_L_W;   // signed high slice of operand b
  localparam int MUL_PP_W = MUL_A_W + MUL_H_W;   // one partial product
  localparam int ACC_W    = 53;
  localparam int DIV_N_W  = 49;   // magnitude of difference shifted up by 16
  localparam int DIV_STEPS = DIV_N_W;
  localparam int DIV_CNT_W = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_INC,
    ST_INTEG,
    ST_MUL_I,
    ST_ACC_I,
    ST_DIV_WAIT,
    ST_MUL_D,
    ST_ACC_D,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### design/pidw_div.sv
`default_nettype none
// bit-serial restoring divider: sat48(trunc((diff << 16) / divisor))
module pidw_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] diff,
  input  wire logic [pidw_pkg::PER_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [pidw_pkg::WIDE_W-1:0] quot
);

  logic [pidw_pkg::DIV_N_W-1:0]   dvd;
  logic [pidw_pkg::DIV_N_W-1:0]   q;
  logic [pidw_pkg::PER_W-1:0]     rem;
  logic [pidw_pkg::PER_W-1:0]     dvs;
  logic [pidw_pkg::DIV_CNT_W-1:0] cnt;
  logic                           neg;
  logic [32:0]                    mag;
  logic [pidw_pkg::PER_W:0]       trial;
  logic                           fits;
  logic [pidw_pkg::DIV_N_W:0]     qs;

  assign mag   = diff[32] ? (33'd0 - diff) : diff;
  assign trial = {rem, dvd[pidw_pkg::DIV_N_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= pidw_pkg::DIV_CNT_W'(pidw_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == pidw_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {mag, {pidw_pkg::PER_W{1'b0}}};
      q   <= '0;
      rem <= '0;
      dvs <= divisor;
      neg <= diff[32];
    end else if (busy) begin
      dvd <= {dvd[pidw_pkg::DIV_N_W-2:0], 1'b0};
      q   <= {q[pidw_pkg::DIV_N_W-2:0], fits};
      rem <= fits ? pidw_pkg::PER_W'(trial - {1'b0, dvs}) : trial[pidw_pkg::PER_W-1:0];
    end
  end

  // signed quotient, clamp to 48 bits; zero divisor gives zero
  always_comb begin
    qs = neg ? ((pidw_pkg::DIV_N_W+1)'(0) - {1'b0, q}) : {1'b0, q};
    if (dvs == '0) begin
      quot = '0;
    end else if (qs[pidw_pkg::DIV_N_W] != qs[pidw_pkg::WIDE_W-1] ||
                 qs[pidw_pkg::DIV_N_W] != qs[pidw_pkg::WIDE_W]) begin
      quot = qs[pidw_pkg::DIV_N_W] ? {1'b1, {(pidw_pkg::WIDE_W-1){1'b0}}}
                                   : {1'b0, {(pidw_pkg::WIDE_W-1){1'b1}}};
    end else begin
      quot = qs[pidw_pkg::WIDE_W-1:0];
    end
  end

endmodule
`default_nettype wire

### design/four_axis_pid_with_windup_guard.sv
`default_nettype none
// four-axis pid controller with integral windup guard
//
// s_* channel: one word per sample period holding measured and target values
//   of every axis (signed Q16.16) and the period dt (unsigned Q0.16)
// m_* channel: one word per input word with the saturated drives of all axes
// cfg_*: gain writes, one 63-bit register per axis (kp, ki, kd as Q3.18),
//   an index at or beyond NUM_AXES is ignored
//
// axes are processed one after another through a single shared 22x25
// multiplier, used in two passes per product, and a bit-serial divider;
// the divider's steps set the pace, and m_tvalid rises once the last axis
// has been finished and its word loaded into the output register
// s_tready is high only while no word is in work, so a new word can be
// taken only after the previous one has been finished
// a finished word waits in the output register; the next input word is taken
// meanwhile, and the block holds before loading a new result until the old
// one has been taken by the receiver
// reset clears gains, integrals, previous errors and previous drives
module four_axis_pid_with_windup_guard #(
  parameter int NUM_AXES = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // meas[0..N-1], goal[0..N-1] (32 bits each), period (16 bits)
  input  wire logic [NUM_AXES*64+15:0]       s_tdata,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // drive[0..N-1], 32 bits each
  output logic [NUM_AXES*32-1:0]             m_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic                          cfg_we,
  input  wire logic [$clog2(NUM_AXES):0]     cfg_index,
  input  wire logic [pidw_pkg::CFG_W-1:0]    cfg_data
);

  localparam int AX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int VW   = pidw_pkg::VAL_W;
  localparam int WW   = pidw_pkg::WIDE_W;
  localparam int GW   = pidw_pkg::GAIN_W;

  pidw_pkg::state_t state, state_next;

  // captured input word
  logic [VW-1:0]                 meas [NUM_AXES];
  logic [VW-1:0]                 goal [NUM_AXES];
  logic [pidw_pkg::PER_W-1:0]    dt;

  // per-axis state
  logic [pidw_pkg::CFG_W-1:0]    gains      [NUM_AXES];
  logic [WW-1:0]                 integ_sum  [NUM_AXES];
  logic [VW-1:0]                 last_err   [NUM_AXES];
  logic [VW-1:0]                 last_drive [NUM_AXES];
  logic [VW-1:0]                 drive_w    [NUM_AXES];

  logic [AX_W-1:0]               ax;
  logic [VW-1:0]                 err_r;
  logic [pidw_pkg::ACC_W-1:0]    acc;

  // shared multiplier
  logic signed [pidw_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [pidw_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [pidw_pkg::MUL_P_W-1:0]  prod;
  logic signed [pidw_pkg::MUL_H_W-1:0]  mul_bs;
  logic signed [pidw_pkg::MUL_PP_W-1:0] pp;
  logic                                 mhalf;
  logic                                 mul_step;

  logic [GW-1:0]                 kp, ki, kd;
  logic [VW:0]                   ediff;
  logic [VW-1:0]                 err_sat;
  logic [32:0]                   inc;
  logic [WW:0]                   isum;
  logic [WW-1:0]                 isat;
  logic                          guard_ok;
  logic [pidw_pkg::ACC_W-1:0]    term;
  logic [pidw_pkg::ACC_W-1:0]    fin;
  logic [VW-1:0]                 fin_sat;
  logic                          last_ax;

  logic                          div_start, div_busy, div_done;
  logic [WW-1:0]                 deriv;

  assign kp = gains[ax][GW-1:0];
  assign ki = gains[ax][2*GW-1:GW];
  assign kd = gains[ax][3*GW-1:2*GW];

  assign s_tready = (state == pidw_pkg::ST_IDLE);
  assign last_ax  = (ax == AX_W'(NUM_AXES-1));

  // error = goal - meas, clamped to 32 bits
  assign ediff = {goal[ax][VW-1], goal[ax]} - {meas[ax][VW-1], meas[ax]};
  always_comb begin
    if (ediff[VW] != ediff[VW-1])
      err_sat = ediff[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    else
      err_sat = ediff[VW-1:0];
  end

  // integral increment floor(err*dt / 2^16), fits 33 bits
  assign inc  = prod[48:16];
  assign isum = {integ_sum[ax][WW-1], integ_sum[ax]} + {{(WW-32){inc[32]}}, inc};
  always_comb begin
    if (isum[WW] != isum[WW-1])
      isat = isum[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    else
      isat = isum[WW-1:0];
  end

  // windup guard: previous drive strictly inside (-1.0, +1.0)
  assign guard_ok = ($signed(last_drive[ax]) < $signed(VW'(65536))) &&
                    ($signed(last_drive[ax]) > $signed(-VW'(65536)));

  // gain term floor(g*v / 2^18)
  assign term = prod[pidw_pkg::MUL_P_W-1:pidw_pkg::GAIN_FR];
  assign fin  = acc + term;
  always_comb begin
    if (fin[pidw_pkg::ACC_W-1:VW-1] != {(pidw_pkg::ACC_W-VW+1){1'b0}} &&
        fin[pidw_pkg::ACC_W-1:VW-1] != {(pidw_pkg::ACC_W-VW+1){1'b1}})
      fin_sat = fin[pidw_pkg::ACC_W-1] ? {1'b1, {(VW-1){1'b0}}}
                                       : {1'b0, {(VW-1){1'b1}}};
    else
      fin_sat = fin[VW-1:0];
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      pidw_pkg::ST_INC: begin
        mul_a = {{(pidw_pkg::MUL_A_W-pidw_pkg::PER_W){1'b0}}, dt};
        mul_b = {{(pidw_pkg::MUL_B_W-VW){err_r[VW-1]}}, err_r};
      end
      pidw_pkg::ST_INTEG: begin
        mul_a = {kp[GW-1], kp};
        mul_b = {{(pidw_pkg::MUL_B_W-VW){err_r[VW-1]}}, err_r};
      end
      pidw_pkg::ST_MUL_I: begin
        mul_a = {ki[GW-1], ki};
        mul_b = {integ_sum[ax][WW-1], integ_sum[ax]};
      end
      pidw_pkg::ST_MUL_D: begin
        mul_a = {kd[GW-1], kd};
        mul_b = {deriv[WW-1], deriv};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // every multiply state makes two passes: low slice first, then high slice
  assign mul_step = state inside {pidw_pkg::ST_INC, pidw_pkg::ST_INTEG,
                                  pidw_pkg::ST_MUL_I, pidw_pkg::ST_MUL_D};
  assign mul_bs   = mhalf ? mul_b[pidw_pkg::MUL_B_W-1:pidw_pkg::MUL_L_W]
                          : {1'b0, mul_b[pidw_pkg::MUL_L_W-1:0]};
  assign pp       = mul_a * mul_bs;

  always_ff @(posedge clk) begin
    if (rst) mhalf <= 1'b0;
    else     mhalf <= mul_step && !mhalf;
  end

  // full product is ready in the cycle after the high pass
  always_ff @(posedge clk) begin
    if (mul_step) begin
      if (!mhalf)
        prod <= {{(pidw_pkg::MUL_P_W-pidw_pkg::MUL_PP_W){pp[pidw_pkg::MUL_PP_W-1]}}, pp};
      else
        prod <= prod + {pp, {pidw_pkg::MUL_L_W{1'b0}}};
    end
  end

  assign div_start = (state == pidw_pkg::ST_INTEG) && !mhalf;

  pidw_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .diff    ({err_r[VW-1], err_r} - {last_err[ax][VW-1], last_err[ax]}),
    .divisor (dt),
    .busy    (div_busy),
    .done    (div_done),
    .quot    (deriv)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      pidw_pkg::ST_IDLE:     if (s_tvalid) state_next = pidw_pkg::ST_ERR;
      pidw_pkg::ST_ERR:      state_next = pidw_pkg::ST_INC;
      pidw_pkg::ST_INC:      if (mhalf) state_next = pidw_pkg::ST_INTEG;
      pidw_pkg::ST_INTEG:    if (mhalf) state_next = pidw_pkg::ST_MUL_I;
      pidw_pkg::ST_MUL_I:    if (mhalf) state_next = pidw_pkg::ST_ACC_I;
      pidw_pkg::ST_ACC_I:    state_next = pidw_pkg::ST_DIV_WAIT;
      pidw_pkg::ST_DIV_WAIT: if (div_done) state_next = pidw_pkg::ST_MUL_D;
      pidw_pkg::ST_MUL_D:    if (mhalf) state_next = pidw_pkg::ST_ACC_D;
      pidw_pkg::ST_ACC_D:    state_next = last_ax ? pidw_pkg::ST_DONE : pidw_pkg::ST_ERR;
      pidw_pkg::ST_DONE:     if (!m_tvalid || m_tready) state_next = pidw_pkg::ST_IDLE;
      default:               state_next = pidw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pidw_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // axis counter, per-axis state, config
  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        gains[i]      <= '0;
        integ_sum[i]  <= '0;
        last_err[i]   <= '0;
        last_drive[i] <= '0;
      end
    end else begin
      if (cfg_we && cfg_index < ($clog2(NUM_AXES)+1)'(NUM_AXES))
        gains[cfg_index[AX_W-1:0]] <= cfg_data;
      case (state)
        pidw_pkg::ST_IDLE: ax <= '0;
        pidw_pkg::ST_INTEG: begin
          // increment product is only valid in the first cycle
          if (guard_ok && !mhalf) integ_sum[ax] <= isat;
        end
        pidw_pkg::ST_ACC_D: begin
          last_drive[ax] <= fin_sat;
          last_err[ax]   <= err_r;
          if (!last_ax) ax <= ax + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == pidw_pkg::ST_IDLE && s_tvalid) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        meas[i] <= s_tdata[32*i +: 32];
        goal[i] <= s_tdata[32*(NUM_AXES+i) +: 32];
      end
      dt <= s_tdata[64*NUM_AXES +: 16];
    end
    if (state == pidw_pkg::ST_ERR)               err_r <= err_sat;
    if (state == pidw_pkg::ST_MUL_I && !mhalf)   acc   <= term;
    if (state == pidw_pkg::ST_ACC_I)             acc   <= fin;
    if (state == pidw_pkg::ST_ACC_D)             drive_w[ax] <= fin_sat;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == pidw_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pidw_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      for (int i = 0; i < NUM_AXES; i++) m_tdata[32*i +: 32] <= drive_w[i];
    end
  end

`ifndef SYNTHESIS
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == pidw_pkg::ST_ERR && ax == '0))
    else $error("accepted word did not start at first axis");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (state == pidw_pkg::ST_ACC_D && last_ax) |=> state == pidw_pkg::ST_DONE)
    else $error("last axis did not finish the word");

  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid) else $error("output valid after reset");
`endif

endmodule
`default_nettype wire
